>>> rtl/belt_pkg.sv
package belt_pkg;

    // Eight 32-bit key words, word 0 in the lowest bits.
    typedef logic [7:0][31:0] t_key_words;

    // Working state of one block as it moves down the round pipeline.
    // The field t carries the sum b + c between the second and third stage of a round.
    typedef struct packed {
        logic        dec;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] t;
    } t_blk;

    typedef enum logic [2:0] {
        CFG_KEY_01 = 3'd0,
        CFG_KEY_23 = 3'd1,
        CFG_KEY_45 = 3'd2,
        CFG_KEY_67 = 3'd3
    } t_cfg_reg;

    localparam int unsigned ROUNDS = 8;

    localparam logic [4:0] ROT_A = 5'd5;
    localparam logic [4:0] ROT_B = 5'd13;
    localparam logic [4:0] ROT_C = 5'd21;

    localparam logic [7:0] SBOX [256] = '{
        8'hB1, 8'h94, 8'hBA, 8'hC8, 8'h0A, 8'h08, 8'hF5, 8'h3B, 8'h36, 8'h6D, 8'h00, 8'h8E,
        8'h58, 8'h4A, 8'h5D, 8'hE4, 8'h85, 8'h04, 8'hFA, 8'h9D, 8'h1B, 8'hB6, 8'hC7, 8'hAC,
        8'h25, 8'h2E, 8'h72, 8'hC2, 8'h02, 8'hFD, 8'hCE, 8'h0D, 8'h5B, 8'hE3, 8'hD6, 8'h12,
        8'h17, 8'hB9, 8'h61, 8'h81, 8'hFE, 8'h67, 8'h86, 8'hAD, 8'h71, 8'h6B, 8'h89, 8'h0B,
        8'h5C, 8'hB0, 8'hC0, 8'hFF, 8'h33, 8'hC3, 8'h56, 8'hB8, 8'h35, 8'hC4, 8'h05, 8'hAE,
        8'hD8, 8'hE0, 8'h7F, 8'h99, 8'hE1, 8'h2B, 8'hDC, 8'h1A, 8'hE2, 8'h82, 8'h57, 8'hEC,
        8'h70, 8'h3F, 8'hCC, 8'hF0, 8'h95, 8'hEE, 8'h8D, 8'hF1, 8'hC1, 8'hAB, 8'h76, 8'h38,
        8'h9F, 8'hE6, 8'h78, 8'hCA, 8'hF7, 8'hC6, 8'hF8, 8'h60, 8'hD5, 8'hBB, 8'h9C, 8'h4F,
        8'hF3, 8'h3C, 8'h65, 8'h7B, 8'h63, 8'h7C, 8'h30, 8'h6A, 8'hDD, 8'h4E, 8'hA7, 8'h79,
        8'h9E, 8'hB2, 8'h3D, 8'h31, 8'h3E, 8'h98, 8'hB5, 8'h6E, 8'h27, 8'hD3, 8'hBC, 8'hCF,
        8'h59, 8'h1E, 8'h18, 8'h1F, 8'h4C, 8'h5A, 8'hB7, 8'h93, 8'hE9, 8'hDE, 8'hE7, 8'h2C,
        8'h8F, 8'h0C, 8'h0F, 8'hA6, 8'h2D, 8'hDB, 8'h49, 8'hF4, 8'h6F, 8'h73, 8'h96, 8'h47,
        8'h06, 8'h07, 8'h53, 8'h16, 8'hED, 8'h24, 8'h7A, 8'h37, 8'h39, 8'hCB, 8'hA3, 8'h83,
        8'h03, 8'hA9, 8'h8B, 8'hF6, 8'h92, 8'hBD, 8'h9B, 8'h1C, 8'hE5, 8'hD1, 8'h41, 8'h01,
        8'h54, 8'h45, 8'hFB, 8'hC9, 8'h5E, 8'h4D, 8'h0E, 8'hF2, 8'h68, 8'h20, 8'h80, 8'hAA,
        8'h22, 8'h7D, 8'h64, 8'h2F, 8'h26, 8'h87, 8'hF9, 8'h34, 8'h90, 8'h40, 8'h55, 8'h11,
        8'hBE, 8'h32, 8'h97, 8'h13, 8'h43, 8'hFC, 8'h9A, 8'h48, 8'hA0, 8'h2A, 8'h88, 8'h5F,
        8'h19, 8'h4B, 8'h09, 8'hA1, 8'h7E, 8'hCD, 8'hA4, 8'hD0, 8'h15, 8'h44, 8'hAF, 8'h8C,
        8'hA5, 8'h84, 8'h50, 8'hBF, 8'h66, 8'hD2, 8'hE8, 8'h8A, 8'hA2, 8'hD7, 8'h46, 8'h52,
        8'h42, 8'hA8, 8'hDF, 8'hB3, 8'h69, 8'h74, 8'hC5, 8'h51, 8'hEB, 8'h23, 8'h29, 8'h21,
        8'hD4, 8'hEF, 8'hD9, 8'hB4, 8'h3A, 8'h62, 8'h28, 8'h75, 8'h91, 8'h14, 8'h10, 8'hEA,
        8'h77, 8'h6C, 8'hDA, 8'h1D
    };

    // Key addition, byte-wise substitution, then a left rotation by rot (never zero).
    function automatic logic [31:0] g_fn(input logic [31:0] x, input logic [31:0] k,
                                         input logic [4:0] rot);
        logic [31:0] u;
        logic [31:0] s;
        u = x + k;
        s = {SBOX[u[31:24]], SBOX[u[23:16]], SBOX[u[15:8]], SBOX[u[7:0]]};
        return (s << rot) | (s >> (6'd32 - {1'b0, rot}));
    endfunction

    // Deciphering walks the key words in reverse order: word m becomes word 7 - m.
    function automatic logic [31:0] key_word(input t_key_words key, input logic dec,
                                             input logic [2:0] m);
        return dec ? key[~m] : key[m];
    endfunction

endpackage

>>> rtl/belt_block_cipher_128.sv
// Channel   Direction  Words carried
// s_axis    in         one 128-bit block and its direction flag
// m_axis    out        the enciphered or deciphered block
// cfg       in         writes to the four 64-bit key registers
//
// One block is accepted every cycle while the spare output register is empty; a result
// passes through the input register, five register stages in each of the eight rounds
// and then the output register.
// Reset clears all valid bits and the key to zero.
// A stall at m_axis freezes the round pipeline once the spare output register
// is full; nothing is dropped or repeated.
module belt_block_cipher_128 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_low [63:0], block_high [127:64]
    input  logic [0:0]   s_axis_tuser,  // decrypt [0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_low [63:0], result_high [127:64]
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import belt_pkg::*;

    logic [3:0][63:0] r_key;
    t_key_words       key_words;
    logic             en;
    logic             r_in_valid;
    t_blk             r_in_blk;
    logic             w_valid [ROUNDS + 1];
    t_blk             w_blk   [ROUNDS + 1];
    t_blk             fin;
    logic [127:0]     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_01: r_key[0] <= i_cfg_data;
                CFG_KEY_23: r_key[1] <= i_cfg_data;
                CFG_KEY_45: r_key[2] <= i_cfg_data;
                CFG_KEY_67: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign key_words = t_key_words'(r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_blk.dec <= s_axis_tuser[0];
            r_in_blk.a   <= s_axis_tdata[31:0];
            r_in_blk.b   <= s_axis_tdata[63:32];
            r_in_blk.c   <= s_axis_tdata[95:64];
            r_in_blk.d   <= s_axis_tdata[127:96];
            r_in_blk.t   <= '0;
        end
    end

    assign w_valid[0]    = r_in_valid;
    assign w_blk[0]      = r_in_blk;
    assign s_axis_tready = en;

    for (genvar gi = 0; gi < ROUNDS; gi++) begin : g_round
        belt_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_round (3'(gi)),
            .i_key   (key_words),
            .i_valid (w_valid[gi]),
            .i_blk   (w_blk[gi]),
            .o_valid (w_valid[gi + 1]),
            .o_blk   (w_blk[gi + 1])
        );
    end

    // Output word order differs by direction.
    assign fin    = w_blk[ROUNDS];
    assign result = fin.dec ? {fin.b, fin.d, fin.a, fin.c} : {fin.c, fin.a, fin.d, fin.b};

    belt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ROUNDS]),
        .i_data  (result),
        .o_ready (en),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

>>> rtl/belt_round.sv
module belt_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [2:0]        i_round,
    input  belt_pkg::t_key_words i_key,
    input  logic              i_valid,
    input  belt_pkg::t_blk    i_blk,
    output logic              o_valid,
    output belt_pkg::t_blk    o_blk
);
    import belt_pkg::*;

    logic [4:0]  r_valid;
    t_blk        r_blk [5];
    t_blk        n_blk [5];
    logic [31:0] e;
    logic [31:0] b1;
    logic [31:0] c1;
    logic [3:0]  ctr;

    // Round i uses key words 7i + s mod 8, which is s - i mod 8.
    always_comb begin
        n_blk[0]   = i_blk;
        n_blk[0].b = i_blk.b ^ g_fn(i_blk.a, key_word(i_key, i_blk.dec, 3'd0 - i_round), ROT_A);
        n_blk[0].c = i_blk.c ^ g_fn(i_blk.d, key_word(i_key, i_blk.dec, 3'd1 - i_round), ROT_C);

        n_blk[1]   = r_blk[0];
        n_blk[1].a = r_blk[0].a
                   - g_fn(r_blk[0].b, key_word(i_key, r_blk[0].dec, 3'd2 - i_round), ROT_B);
        n_blk[1].t = r_blk[0].b + r_blk[0].c;

        ctr = r_blk[1].dec ? (4'd8 - {1'b0, i_round}) : ({1'b0, i_round} + 4'd1);
        e   = g_fn(r_blk[1].t, key_word(i_key, r_blk[1].dec, 3'd3 - i_round), ROT_C)
            ^ {28'd0, ctr};
        n_blk[2]   = r_blk[1];
        n_blk[2].b = r_blk[1].b + e;
        n_blk[2].c = r_blk[1].c - e;

        n_blk[3]   = r_blk[2];
        n_blk[3].d = r_blk[2].d
                   + g_fn(r_blk[2].c, key_word(i_key, r_blk[2].dec, 3'd4 - i_round), ROT_B);

        b1 = r_blk[3].b
           ^ g_fn(r_blk[3].a, key_word(i_key, r_blk[3].dec, 3'd5 - i_round), ROT_C);
        c1 = r_blk[3].c
           ^ g_fn(r_blk[3].d, key_word(i_key, r_blk[3].dec, 3'd6 - i_round), ROT_A);
        n_blk[4] = r_blk[3];
        // End-of-round word swaps, folded into one permutation for each direction.
        if (r_blk[3].dec) begin
            n_blk[4].a = c1;
            n_blk[4].b = r_blk[3].a;
            n_blk[4].c = r_blk[3].d;
            n_blk[4].d = b1;
        end else begin
            n_blk[4].a = b1;
            n_blk[4].b = r_blk[3].d;
            n_blk[4].c = r_blk[3].a;
            n_blk[4].d = c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 5; k++) begin
                r_blk[k] <= n_blk[k];
            end
        end
    end

    assign o_valid = r_valid[4];
    assign o_blk   = r_blk[4];

endmodule

>>> rtl/belt_skid.sv
module belt_skid (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [127:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [127:0] o_data,
    input  logic         i_ready
);
    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_skid_valid;
    logic [127:0] r_skid_data;

    // The upstream side sees only whether the spare register is empty.
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (!r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

>>> rtl/belt_chk.sv
module belt_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // Nothing is offered on the output straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word offered right after reset");

    // A held word stays put until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed or vanished");

    // Input back-pressure only arises while a finished word waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output word waiting");

    // Once the output takes a word, the spare register is empty again.
    a_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("input not ready after output word taken");

endmodule

bind belt_block_cipher_128 belt_chk u_belt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/belt_cipher_check_pkg.sv
package belt_cipher_check_pkg;

    typedef logic [7:0][31:0] key_set_t;

    localparam int unsigned KEY_SLOTS = 4;
    localparam int unsigned CIPHER_ROUNDS = 8;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned ROT_SHORT = 5;
    localparam int unsigned ROT_MID = 13;
    localparam int unsigned ROT_LONG = 21;

    // Substitution table, entry 0 in the leftmost byte of the first row.
    localparam logic [0:255][7:0] BELT_SUBST = {
        128'hB194BAC80A08F53B366D008E584A5DE4,
        128'h8504FA9D1BB6C7AC252E72C202FDCE0D,
        128'h5BE3D61217B96181FE6786AD716B890B,
        128'h5CB0C0FF33C356B835C405AED8E07F99,
        128'hE12BDC1AE28257EC703FCCF095EE8DF1,
        128'hC1AB76389FE678CAF7C6F860D5BB9C4F,
        128'hF33C657B637C306ADD4EA7799EB23D31,
        128'h3E98B56E27D3BCCF591E181F4C5AB793,
        128'hE9DEE72C8F0C0FA62DDB49F46F739647,
        128'h06075316ED247A3739CBA38303A98BF6,
        128'h92BD9B1CE5D141015445FBC95E4D0EF2,
        128'h682080AA227D642F2687F93490405511,
        128'hBE32971343FC9A48A02A885F194B09A1,
        128'h7ECDA4D01544AF8CA58450BF66D2E88A,
        128'hA2D7465242A8DFB36974C551EB232921,
        128'hD4EFD9B43A622875911410EA776CDA1D
    };

    function automatic logic [31:0] mix_word(input logic [31:0] x, input logic [31:0] k,
                                             input int unsigned rot);
        logic [31:0] u;
        logic [31:0] s;
        u = x + k;
        for (int n = 0; n < 4; n++) begin
            s[8*n +: 8] = BELT_SUBST[u[8*n +: 8]];
        end
        return (s << rot) | (s >> (32 - rot));
    endfunction

    // Full eight-round transform of one 128-bit word in either direction.
    function automatic logic [127:0] belt_transform(input key_set_t key,
                                                    input logic [127:0] blk,
                                                    input logic dec);
        key_set_t    kw;
        logic [31:0] a, b, c, d, e, t;
        int unsigned j;
        a = blk[31:0];
        b = blk[63:32];
        c = blk[95:64];
        d = blk[127:96];
        for (int m = 0; m < 8; m++) begin
            kw[m] = dec ? key[7 - m] : key[m];
        end
        for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            j = 7 * r;
            b = b ^ mix_word(a, kw[(j + 0) % 8], ROT_SHORT);
            c = c ^ mix_word(d, kw[(j + 1) % 8], ROT_LONG);
            a = a - mix_word(b, kw[(j + 2) % 8], ROT_MID);
            e = mix_word(b + c, kw[(j + 3) % 8], ROT_LONG);
            e = e ^ (dec ? 32'(CIPHER_ROUNDS - r) : 32'(r + 1));
            b = b + e;
            c = c - e;
            d = d + mix_word(c, kw[(j + 4) % 8], ROT_MID);
            b = b ^ mix_word(a, kw[(j + 5) % 8], ROT_LONG);
            c = c ^ mix_word(d, kw[(j + 6) % 8], ROT_SHORT);
            t = a; a = b; b = t;
            t = c; c = d; d = t;
            if (dec) begin
                t = a; a = d; d = t;
            end else begin
                t = b; b = c; c = t;
            end
        end
        return dec ? {b, d, a, c} : {c, a, d, b};
    endfunction

    class belt_block_board;
        key_set_t     key;
        logic [127:0] pending[$];
        int unsigned  mismatches;
        int unsigned  blocks_in;
        int unsigned  blocks_dec;
        int unsigned  results_out;
        int unsigned  key_writes;
        int unsigned  stray_writes;

        function new();
            key = '0;
            mismatches = 0;
            blocks_in = 0;
            blocks_dec = 0;
            results_out = 0;
            key_writes = 0;
            stray_writes = 0;
        endfunction

        // Writes to indexes past the last key register leave the key alone.
        function void load_key(input logic [2:0] idx, input logic [63:0] val);
            if (idx < KEY_SLOTS) begin
                key[2*idx]     = val[31:0];
                key[2*idx + 1] = val[63:32];
                key_writes++;
            end else begin
                stray_writes++;
            end
        endfunction

        function void note_block(input logic [127:0] blk, input logic dec);
            blocks_in++;
            if (dec) blocks_dec++;
            pending.push_back(belt_transform(key, blk, dec));
        endfunction

        function void flag_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected %h, got %h", results_out, field, want, got);
        endfunction

        function void check_result(input logic [127:0] got);
            logic [127:0] want;
            results_out++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: %h arrived with no block outstanding",
                             results_out, got);
                return;
            end
            want = pending.pop_front();
            if (got[63:0] !== want[63:0])
                flag_field("result_low", want[63:0], got[63:0]);
            if (got[127:64] !== want[127:64])
                flag_field("result_high", want[127:64], got[127:64]);
        endfunction

        function int unsigned pending_count();
            return pending.size();
        endfunction
    endclass

endpackage

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import belt_pkg::*;
    import belt_cipher_check_pkg::*;

    localparam int unsigned IDLE_PCT = 28;
    localparam int unsigned STUCK_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned KEY_PHASES = 10;
    localparam int unsigned STEADY_PHASE = 4;
    localparam int unsigned BLOCKS_PER_PHASE = 154;
    localparam t_cfg_reg KEY_REGS [KEY_SLOTS] = '{CFG_KEY_01, CFG_KEY_23, CFG_KEY_45,
                                                   CFG_KEY_67};

    // Published test key and plaintext of the standard, as little-endian words.
    localparam logic [255:0] STD_KEY = {64'hF68BA90383A3CB39, 64'h377A24ED16530706,
                                        64'h4796736FF449DB2D, 64'hA60F0C8F2CE7DEE9};
    localparam logic [127:0] STD_PLAIN = {64'hE45D4A588E006D36, 64'h3BF5080AC8BA94B1};
    localparam logic [127:0] STD_CIPHER = {64'h6EFA88FAE0C36BD6, 64'hE3C95735C9A1CC69};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // block_low [63:0], block_high [127:64]
    logic [0:0]   s_axis_tuser = '0;   // decrypt [0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // result_low [63:0], result_high [127:64]
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    belt_block_board board;
    logic         steady = 1'b0;
    int unsigned  stuck_cycles = 0;
    int unsigned  round_trips = 0;
    int unsigned  key_sets = 1;

    belt_block_cipher_128 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Key writes are mirrored first so that a word and a write at one edge stay ordered.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.load_key(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.note_block(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("no word moved for %0d cycles", STUCK_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic dec);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hi, lo};
        s_axis_tuser <= dec;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic await_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // A stray write to an unused index goes in among the real ones and must change nothing.
    task automatic load_key_set(input logic [255:0] kv);
        logic [2:0] stray;
        stray = 3'(KEY_SLOTS + $urandom_range(KEY_SLOTS - 1));
        await_drain();
        for (int n = 0; n < KEY_SLOTS; n++) begin
            write_cfg(KEY_REGS[n], kv[64*n +: 64]);
            if (n == 1)
                write_cfg(stray, {$urandom, $urandom});
        end
        key_sets++;
    endtask

    function automatic logic [63:0] sparse_field();
        logic [63:0] one_hot;
        one_hot = 64'h1 << $urandom_range(63);
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return one_hot;
            default: return ~one_hot;
        endcase
    endfunction

    // Mostly random blocks; some go through and straight back the other way, each result checked
    // against belt_transform like every other block, and some carry sparse bit patterns.
    task automatic random_blocks(input int unsigned count);
        logic [63:0]  lo, hi;
        logic [127:0] fwd;
        logic         dec;
        int unsigned  pick;
        repeat (count) begin
            pick = $urandom_range(99);
            dec = 1'($urandom_range(1));
            if (pick < 45) begin
                lo = sparse_field();
                hi = sparse_field();
            end else begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            send_block(lo, hi, dec);
            if (pick < 30) begin
                fwd = belt_transform(board.key, {hi, lo}, dec);
                send_block(fwd[63:0], fwd[127:64], !dec);
                round_trips++;
            end
        end
    endtask

    initial begin
        logic [255:0] kv;
        logic [63:0]  pat_lo [6];
        logic [63:0]  pat_hi [6];
        board = new();
        pat_lo = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1, 64'h0};
        pat_hi = '{64'h0, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0,
                   64'h8000_0000_0000_0000};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme blocks in both directions under the all-zero key left by reset.
        for (int dir = 0; dir < 2; dir++) begin
            for (int n = 0; n < 6; n++) begin
                send_block(pat_lo[n], pat_hi[n], dir[0]);
            end
        end
        random_blocks(BLOCKS_PER_PHASE);

        for (int p = 1; p < KEY_PHASES; p++) begin
            case (p)
                1: kv = '1;
                2: kv = STD_KEY;
                3: kv = '0;
                4: kv = {4{64'h5555_5555_AAAA_AAAA}};
                default: begin
                    for (int n = 0; n < 8; n++) kv[32*n +: 32] = $urandom;
                end
            endcase
            load_key_set(kv);
            steady = (p == STEADY_PHASE);
            if (p == 2) begin
                send_block(STD_PLAIN[63:0], STD_PLAIN[127:64], 1'b0);
                send_block(STD_CIPHER[63:0], STD_CIPHER[127:64], 1'b1);
            end
            random_blocks(BLOCKS_PER_PHASE);
        end

        await_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d blocks (%0d to decipher, %0d round trips), checked %0d results.",
                 board.blocks_in, board.blocks_dec, round_trips, board.results_out);
        $display("Used %0d key settings with %0d key writes and %0d writes to unused indexes.",
                 key_sets, board.key_writes, board.stray_writes);
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", board.mismatches,
                     board.pending_count());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
